>>> design/bra_pkg.sv
package bra_pkg;

    localparam int NUM_SLOTS_DEF      = 4096;
    localparam int FIRST_ORDINARY_DEF = 24;

    localparam int WORD_BITS = 64;
    localparam int POS_W     = 6;
    localparam int SEQ_W     = 16;
    localparam int REC_W     = 12;
    localparam int BASE_W    = 48;
    localparam int STATUS_W  = 3;
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 12;

    localparam logic [REC_W-1:0] LAST_RES_RST = 12'd15;

    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_PARAM = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_STATE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_READ_ONLY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_RES  = 1'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_ALLOC,
        S_GROW,
        S_FULL,
        S_FREE,
        S_QUERY
    } t_state;

    typedef struct packed {
        logic                 hit;
        logic [POS_W-1:0]     pos;
        logic [WORD_BITS-1:0] masked;
    } t_scan_res;

endpackage

>>> design/bra_ram.sv
module bra_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/bra_scan.sv
module bra_scan #(
    parameter int TS_W           = 13,
    parameter int FIRST_ORDINARY = bra_pkg::FIRST_ORDINARY_DEF
) (
    input  logic [bra_pkg::WORD_BITS-1:0] i_raw,
    input  logic [TS_W-7:0]               i_word,
    input  logic [TS_W-1:0]               i_ts,
    output bra_pkg::t_scan_res            o_res
);

    localparam int WW      = TS_W - 6;
    localparam int FO_WORD = FIRST_ORDINARY / 64;
    localparam int FO_LOW  = FIRST_ORDINARY % 64;
    localparam logic [bra_pkg::WORD_BITS-1:0] FO_MASK = (64'd1 << FO_LOW) - 64'd1;

    logic [WW-1:0]                 ts_word;
    logic [bra_pkg::POS_W-1:0]     ts_bit;
    logic [bra_pkg::WORD_BITS-1:0] lt_mask;
    logic [bra_pkg::WORD_BITS-1:0] fo_mask;
    logic [bra_pkg::WORD_BITS-1:0] free_vec;
    logic [bra_pkg::POS_W-1:0]     pos;

    assign ts_word = i_ts[TS_W-1:6];
    assign ts_bit  = i_ts[5:0];

    always_comb begin
        if (i_word < ts_word) begin
            lt_mask = '1;
        end else if (i_word == ts_word) begin
            lt_mask = (64'd1 << ts_bit) - 64'd1;
        end else begin
            lt_mask = '0;
        end

        if (i_word < WW'(FO_WORD)) begin
            fo_mask = '1;
        end else if (i_word == WW'(FO_WORD)) begin
            fo_mask = FO_MASK;
        end else begin
            fo_mask = '0;
        end
    end

    // lowest clear bit inside the ordinary part of the table
    always_comb begin
        free_vec = ~i_raw & lt_mask & ~fo_mask;
        pos = '0;
        for (int i = bra_pkg::WORD_BITS - 1; i >= 0; i--) begin
            if (free_vec[i]) begin
                pos = bra_pkg::POS_W'(i);
            end
        end
    end

    assign o_res.hit    = |free_vec;
    assign o_res.pos    = pos;
    assign o_res.masked = fo_mask | (i_raw & lt_mask);

endmodule

>>> design/bitmap_record_allocator_unit.sv
// record slot allocator over an in-use bitmap with a sequence number per slot
// request channel: i_in_valid / o_in_stall with opcode, record number and base
// reference; one request is worked on at a time and o_in_stall stays high
// until its result has been placed in the output register
// result channel: o_out_valid / i_out_stall, one result per request, held
// unchanged while the receiver stalls; the block waits for a free output
// register before it commits any change to the bitmap or sequence store
// config channel: i_cfg_valid / o_cfg_ready, always ready, index 0 is the
// read only flag and index 1 the last reserved record
// free and query: after decode the bitmap word and sequence are read at once
// allocate: one bitmap word of 64 slots is examined per cycle from the word
// holding the first ordinary slot up to the word holding the last table slot,
// through the single bitmap read port and search unit; the result is
// registered once the output register is free
// the next request can be taken in the cycle after the result is registered
// reset: reserved slots read as in use, table size is the first ordinary slot
// count, sequences read as zero; bitmap contents above the table size are
// masked and sequences are written when the table grows, so no clearing pass
module bitmap_record_allocator_unit #(
    parameter int NUM_SLOTS      = bra_pkg::NUM_SLOTS_DEF,
    parameter int FIRST_ORDINARY = bra_pkg::FIRST_ORDINARY_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [bra_pkg::OP_W-1:0]        i_opcode,
    input  logic [bra_pkg::REC_W-1:0]       i_record_number,
    input  logic [bra_pkg::BASE_W-1:0]      i_base_record,
    input  logic [bra_pkg::SEQ_W-1:0]       i_base_sequence,

    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [bra_pkg::STATUS_W-1:0]    o_status,
    output logic [bra_pkg::REC_W-1:0]       o_slot,
    output logic [bra_pkg::SEQ_W-1:0]       o_slot_sequence,
    output logic                            o_in_use,

    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bra_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bra_pkg::CFG_DAT_W-1:0]   i_cfg_data
);

    localparam int SW        = $clog2(NUM_SLOTS);
    localparam int TSW       = SW + 1;
    localparam int WW        = SW - 5;
    localparam int MAP_WORDS = (NUM_SLOTS + 63) / 64;
    localparam int MAW       = (SW > 6) ? SW - 6 : 1;
    localparam int CW        = (TSW > 13) ? TSW : 13;
    localparam int FO_WORD   = FIRST_ORDINARY / 64;

    bra_pkg::t_state r_state, n_state;

    logic [bra_pkg::OP_W-1:0]    r_op;
    logic [bra_pkg::REC_W-1:0]   r_rec;
    logic                        r_alloc_ok;
    logic [SW-1:0]               r_slot, n_slot;
    logic [WW-1:0]               r_rd_word, n_rd_word;
    logic [WW-1:0]               r_out_word, n_out_word;
    logic                        r_chk_v, n_chk_v;
    logic [TSW-1:0]              r_ts, n_ts;
    logic                        r_read_only;
    logic [bra_pkg::REC_W-1:0]   r_last_res;

    logic                          r_o_valid;
    logic [bra_pkg::STATUS_W-1:0]  r_o_status, n_o_status;
    logic [bra_pkg::REC_W-1:0]     r_o_slot, n_o_slot;
    logic [bra_pkg::SEQ_W-1:0]     r_o_seq, n_o_seq;
    logic                          r_o_in_use, n_o_in_use;
    logic                          emit;

    logic                          in_accept;
    logic                          out_free;
    logic [SW-1:0]                 rec_slot;
    logic [WW-1:0]                 rec_word;
    logic [WW-1:0]                 slot_word;
    logic [WW-1:0]                 ts_word;
    logic [TSW-1:0]                ts_m1;
    logic [WW-1:0]                 last_word;
    logic [SW-1:0]                 hit_slot;
    logic                          rec_lt_fo;
    logic                          rec_lt_ts;
    logic [bra_pkg::WORD_BITS-1:0] slot_onehot;
    logic                          slot_bit;
    logic                          dec_err;
    logic [bra_pkg::STATUS_W-1:0]  dec_st;
    logic [bra_pkg::SEQ_W-1:0]     alloc_seq;
    logic [bra_pkg::SEQ_W-1:0]     free_seq;

    logic                          map_rd_en;
    logic [WW-1:0]                 map_rd_word;
    logic [bra_pkg::WORD_BITS-1:0] map_rd_data;
    logic                          map_wr_en;
    logic [bra_pkg::WORD_BITS-1:0] map_wr_data;
    logic                          seq_rd_en;
    logic [SW-1:0]                 seq_rd_addr;
    logic [bra_pkg::SEQ_W-1:0]     seq_rd_data;
    logic                          seq_wr_en;
    logic [bra_pkg::SEQ_W-1:0]     seq_wr_data;

    bra_pkg::t_scan_res            scan;

    bra_ram #(
        .WIDTH (bra_pkg::WORD_BITS),
        .DEPTH (MAP_WORDS),
        .AW    (MAW)
    ) u_map_ram (
        .i_clk     (i_clk),
        .i_wr_en   (map_wr_en),
        .i_wr_addr (MAW'(slot_word)),
        .i_wr_data (map_wr_data),
        .i_rd_en   (map_rd_en),
        .i_rd_addr (MAW'(map_rd_word)),
        .o_rd_data (map_rd_data)
    );

    bra_ram #(
        .WIDTH (bra_pkg::SEQ_W),
        .DEPTH (NUM_SLOTS),
        .AW    (SW)
    ) u_seq_ram (
        .i_clk     (i_clk),
        .i_wr_en   (seq_wr_en),
        .i_wr_addr (r_slot),
        .i_wr_data (seq_wr_data),
        .i_rd_en   (seq_rd_en),
        .i_rd_addr (seq_rd_addr),
        .o_rd_data (seq_rd_data)
    );

    bra_scan #(
        .TS_W           (TSW),
        .FIRST_ORDINARY (FIRST_ORDINARY)
    ) u_scan (
        .i_raw  (map_rd_data),
        .i_word (r_out_word),
        .i_ts   (r_ts),
        .o_res  (scan)
    );

    assign o_in_stall  = (r_state != bra_pkg::S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_free    = !r_o_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;

    assign rec_slot    = SW'(r_rec);
    assign rec_word    = WW'(rec_slot >> 6);
    assign slot_word   = WW'(r_slot >> 6);
    assign ts_word     = WW'(r_ts >> 6);
    assign ts_m1       = r_ts - TSW'(1);
    assign last_word   = WW'(ts_m1 >> 6);
    assign hit_slot    = SW'({r_out_word, scan.pos});
    assign rec_lt_fo   = CW'(r_rec) < CW'(FIRST_ORDINARY);
    assign rec_lt_ts   = CW'(r_rec) < CW'(r_ts);
    assign slot_onehot = 64'd1 << r_slot[5:0];
    assign slot_bit    = scan.masked[r_slot[5:0]];
    assign alloc_seq   = (seq_rd_data == '0) ? bra_pkg::SEQ_W'(1) : seq_rd_data;
    assign free_seq    = (seq_rd_data == '1) ? bra_pkg::SEQ_W'(1)
                                             : seq_rd_data + bra_pkg::SEQ_W'(1);

    always_comb begin
        dec_err = 1'b0;
        dec_st  = bra_pkg::ST_OK;
        unique case (r_op)
            bra_pkg::OP_ALLOC: begin
                if (r_read_only || !r_alloc_ok) begin
                    dec_err = 1'b1;
                    dec_st  = bra_pkg::ST_BAD_STATE;
                end
            end
            bra_pkg::OP_FREE: begin
                if (r_read_only) begin
                    dec_err = 1'b1;
                    dec_st  = bra_pkg::ST_BAD_STATE;
                end else if (rec_lt_fo) begin
                    dec_err = 1'b1;
                    dec_st  = bra_pkg::ST_BAD_PARAM;
                end else if (!rec_lt_ts) begin
                    dec_err = 1'b1;
                    dec_st  = bra_pkg::ST_RANGE;
                end
            end
            bra_pkg::OP_QUERY: begin
                if (!rec_lt_ts) begin
                    dec_err = 1'b1;
                    dec_st  = bra_pkg::ST_RANGE;
                end
            end
            default: begin
                dec_err = 1'b1;
                dec_st  = bra_pkg::ST_BAD_PARAM;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_slot      = r_slot;
        n_rd_word   = r_rd_word;
        n_out_word  = r_out_word;
        n_chk_v     = r_chk_v;
        n_ts        = r_ts;
        map_rd_en   = 1'b0;
        map_rd_word = r_rd_word;
        map_wr_en   = 1'b0;
        map_wr_data = scan.masked | slot_onehot;
        seq_rd_en   = 1'b0;
        seq_rd_addr = rec_slot;
        seq_wr_en   = 1'b0;
        seq_wr_data = alloc_seq;
        emit        = 1'b0;
        n_o_status  = bra_pkg::ST_OK;
        n_o_slot    = '0;
        n_o_seq     = '0;
        n_o_in_use  = 1'b0;

        unique case (r_state)
            bra_pkg::S_IDLE: begin
                if (in_accept) begin
                    n_state = bra_pkg::S_DECODE;
                end
            end
            bra_pkg::S_DECODE: begin
                if (dec_err) begin
                    if (out_free) begin
                        emit       = 1'b1;
                        n_o_status = dec_st;
                        n_o_slot   = (r_op == bra_pkg::OP_ALLOC) ? '0 : r_rec;
                        n_state    = bra_pkg::S_IDLE;
                    end
                end else if (r_op == bra_pkg::OP_ALLOC) begin
                    n_rd_word = WW'(FO_WORD);
                    n_chk_v   = 1'b0;
                    n_state   = bra_pkg::S_SCAN;
                end else begin
                    map_rd_en   = 1'b1;
                    map_rd_word = rec_word;
                    n_out_word  = rec_word;
                    seq_rd_en   = 1'b1;
                    n_slot      = rec_slot;
                    n_state     = (r_op == bra_pkg::OP_FREE) ? bra_pkg::S_FREE
                                                             : bra_pkg::S_QUERY;
                end
            end
            bra_pkg::S_SCAN: begin
                if (r_chk_v && scan.hit) begin
                    n_slot      = hit_slot;
                    seq_rd_en   = 1'b1;
                    seq_rd_addr = hit_slot;
                    n_state     = bra_pkg::S_ALLOC;
                end else if (r_rd_word > last_word) begin
                    n_slot = SW'(r_ts);
                    if (r_ts == TSW'(NUM_SLOTS)) begin
                        n_state = bra_pkg::S_FULL;
                    end else begin
                        map_rd_en   = 1'b1;
                        map_rd_word = ts_word;
                        n_out_word  = ts_word;
                        n_state     = bra_pkg::S_GROW;
                    end
                end else begin
                    map_rd_en   = 1'b1;
                    map_rd_word = r_rd_word;
                    n_out_word  = r_rd_word;
                    n_chk_v     = 1'b1;
                    n_rd_word   = r_rd_word + WW'(1);
                end
            end
            bra_pkg::S_ALLOC: begin
                if (out_free) begin
                    map_wr_en  = 1'b1;
                    seq_wr_en  = 1'b1;
                    emit       = 1'b1;
                    n_o_slot   = bra_pkg::REC_W'(r_slot);
                    n_o_seq    = alloc_seq;
                    n_o_in_use = 1'b1;
                    n_state    = bra_pkg::S_IDLE;
                end
            end
            bra_pkg::S_GROW: begin
                if (out_free) begin
                    map_wr_en   = 1'b1;
                    seq_wr_en   = 1'b1;
                    seq_wr_data = bra_pkg::SEQ_W'(1);
                    n_ts        = r_ts + TSW'(1);
                    emit        = 1'b1;
                    n_o_slot    = bra_pkg::REC_W'(r_slot);
                    n_o_seq     = bra_pkg::SEQ_W'(1);
                    n_o_in_use  = 1'b1;
                    n_state     = bra_pkg::S_IDLE;
                end
            end
            bra_pkg::S_FULL: begin
                if (out_free) begin
                    emit       = 1'b1;
                    n_o_status = bra_pkg::ST_FULL;
                    n_state    = bra_pkg::S_IDLE;
                end
            end
            bra_pkg::S_FREE: begin
                if (out_free) begin
                    emit     = 1'b1;
                    n_o_slot = r_rec;
                    n_state  = bra_pkg::S_IDLE;
                    if (!slot_bit) begin
                        n_o_status = bra_pkg::ST_NOT_ALLOC;
                    end else begin
                        map_wr_en   = 1'b1;
                        map_wr_data = scan.masked & ~slot_onehot;
                        seq_wr_en   = 1'b1;
                        seq_wr_data = free_seq;
                        n_o_seq     = free_seq;
                    end
                end
            end
            bra_pkg::S_QUERY: begin
                if (out_free) begin
                    emit       = 1'b1;
                    n_o_slot   = r_rec;
                    n_o_seq    = rec_lt_fo ? '0 : seq_rd_data;
                    n_o_in_use = slot_bit;
                    n_state    = bra_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bra_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bra_pkg::S_IDLE;
            r_chk_v     <= 1'b0;
            r_ts        <= TSW'(FIRST_ORDINARY);
            r_o_valid   <= 1'b0;
            r_read_only <= 1'b0;
            r_last_res  <= bra_pkg::LAST_RES_RST;
        end else begin
            r_state <= n_state;
            r_chk_v <= n_chk_v;
            r_ts    <= n_ts;
            if (emit) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    bra_pkg::CFG_READ_ONLY: r_read_only <= i_cfg_data[0];
                    bra_pkg::CFG_LAST_RES:  r_last_res  <= i_cfg_data[bra_pkg::REC_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op       <= i_opcode;
            r_rec      <= i_record_number;
            r_alloc_ok <= (i_base_sequence != '0) && (i_base_record[47:32] == '0)
                          && (i_base_record > bra_pkg::BASE_W'(r_last_res));
        end
        r_slot     <= n_slot;
        r_rd_word  <= n_rd_word;
        r_out_word <= n_out_word;
        if (emit) begin
            r_o_status <= n_o_status;
            r_o_slot   <= n_o_slot;
            r_o_seq    <= n_o_seq;
            r_o_in_use <= n_o_in_use;
        end
    end

    assign o_out_valid     = r_o_valid;
    assign o_status        = r_o_status;
    assign o_slot          = r_o_slot;
    assign o_slot_sequence = r_o_seq;
    assign o_in_use        = r_o_in_use;

endmodule

>>> test/tb_bitmap_record_allocator_unit.sv
module tb_bitmap_record_allocator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSL       = bra_pkg::NUM_SLOTS_DEF;
    localparam int FO        = bra_pkg::FIRST_ORDINARY_DEF;
    localparam int OP_W      = bra_pkg::OP_W;
    localparam int BASE_W    = bra_pkg::BASE_W;
    localparam int STATUS_W  = bra_pkg::STATUS_W;
    localparam int REC_W     = bra_pkg::REC_W;
    localparam int SEQ_W     = bra_pkg::SEQ_W;
    localparam int CFG_IDX_W = bra_pkg::CFG_IDX_W;
    localparam int CFG_DAT_W = bra_pkg::CFG_DAT_W;

    localparam logic [REC_W-1:0]     LAST_RES_RST  = bra_pkg::LAST_RES_RST;
    localparam logic [OP_W-1:0]      OP_ALLOC      = bra_pkg::OP_ALLOC;
    localparam logic [OP_W-1:0]      OP_FREE       = bra_pkg::OP_FREE;
    localparam logic [OP_W-1:0]      OP_QUERY      = bra_pkg::OP_QUERY;
    localparam logic [STATUS_W-1:0]  ST_OK         = bra_pkg::ST_OK;
    localparam logic [STATUS_W-1:0]  ST_BAD_PARAM  = bra_pkg::ST_BAD_PARAM;
    localparam logic [STATUS_W-1:0]  ST_BAD_STATE  = bra_pkg::ST_BAD_STATE;
    localparam logic [STATUS_W-1:0]  ST_NOT_ALLOC  = bra_pkg::ST_NOT_ALLOC;
    localparam logic [STATUS_W-1:0]  ST_RANGE      = bra_pkg::ST_RANGE;
    localparam logic [STATUS_W-1:0]  ST_FULL       = bra_pkg::ST_FULL;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_ONLY = bra_pkg::CFG_READ_ONLY;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_RES  = bra_pkg::CFG_LAST_RES;

    localparam logic [OP_W-1:0]   OP_UNUSED      = 2'd3;
    localparam logic [BASE_W-1:0] BASE_MAX_OK    = 48'h0000_ffff_ffff;
    localparam int                WATCHDOG_LIMIT = 4000;
    localparam int                DRAIN_CYCLES   = 100;
    localparam int                PHASE_ITEMS    = 75;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [REC_W-1:0]    slot;
        logic [SEQ_W-1:0]    seq;
        logic                in_use;
    } t_slot_result;

    class allocator_scoreboard;
        bit               slot_used [NSL];
        logic [SEQ_W-1:0] slot_seq [NSL];
        int               table_size;
        int               used_count;
        bit               read_only;
        logic [REC_W-1:0] last_reserved;
        t_slot_result     awaited_results [$];
        int               mismatches;
        int               results_checked;
        int               requests_noted;
        int               grants;
        int               seq_wraps;
        int               status_count [8];

        function void clear();
            for (int i = 0; i < NSL; i++) begin
                slot_used[i] = (i < FO);
                slot_seq[i]  = '0;
            end
            table_size    = FO;
            used_count    = FO;
            read_only     = 1'b0;
            last_reserved = LAST_RES_RST;
            awaited_results.delete();
            mismatches      = 0;
            results_checked = 0;
            requests_noted  = 0;
            grants          = 0;
            seq_wraps       = 0;
            for (int i = 0; i < 8; i++) begin
                status_count[i] = 0;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
            if (idx == CFG_READ_ONLY) begin
                read_only = data[0];
            end else if (idx == CFG_LAST_RES) begin
                last_reserved = data;
            end
        endfunction

        function t_slot_result allocator_outcome(logic [OP_W-1:0] op, logic [REC_W-1:0] rec,
                                                 logic [BASE_W-1:0] base,
                                                 logic [SEQ_W-1:0] bseq);
            t_slot_result     r;
            int               s;
            logic [SEQ_W-1:0] sq;
            r.status = ST_OK;
            r.slot   = rec;
            r.seq    = '0;
            r.in_use = 1'b0;
            case (op)
                OP_ALLOC: begin
                    r.slot = '0;
                    if (read_only || bseq == '0 || base <= {36'd0, last_reserved} ||
                        base > BASE_MAX_OK) begin
                        r.status = ST_BAD_STATE;
                        return r;
                    end
                    s = FO;
                    while (s < table_size && slot_used[s]) begin
                        s++;
                    end
                    if (s == table_size) begin
                        if (table_size >= NSL) begin
                            r.status = ST_FULL;
                            return r;
                        end
                        table_size++;
                        sq = 16'd1;
                    end else begin
                        sq = (slot_seq[s] == '0) ? 16'd1 : slot_seq[s];
                    end
                    slot_seq[s]  = sq;
                    slot_used[s] = 1'b1;
                    used_count++;
                    grants++;
                    r.slot   = s[REC_W-1:0];
                    r.seq    = sq;
                    r.in_use = 1'b1;
                end
                OP_FREE: begin
                    if (read_only) begin
                        r.status = ST_BAD_STATE;
                    end else if (rec < FO) begin
                        r.status = ST_BAD_PARAM;
                    end else if (rec >= table_size) begin
                        r.status = ST_RANGE;
                    end else if (!slot_used[rec]) begin
                        r.status = ST_NOT_ALLOC;
                    end else begin
                        sq = slot_seq[rec] + 16'd1;
                        if (sq == '0) begin
                            sq = 16'd1;
                            seq_wraps++;
                        end
                        slot_seq[rec]  = sq;
                        slot_used[rec] = 1'b0;
                        used_count--;
                        r.seq = sq;
                    end
                end
                OP_QUERY: begin
                    if (rec >= table_size) begin
                        r.status = ST_RANGE;
                    end else begin
                        r.seq    = slot_seq[rec];
                        r.in_use = slot_used[rec];
                    end
                end
                default: begin
                    r.status = ST_BAD_PARAM;
                end
            endcase
            return r;
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic [REC_W-1:0] rec,
                                   logic [BASE_W-1:0] base, logic [SEQ_W-1:0] bseq);
            awaited_results.push_back(allocator_outcome(op, rec, base, bseq));
            requests_noted++;
        endfunction

        task report(string msg);
            mismatches++;
            $display("%t mismatch: %s", $realtime, msg);
        endtask

        task check_result(logic [STATUS_W-1:0] status, logic [REC_W-1:0] slot,
                          logic [SEQ_W-1:0] seq, logic in_use);
            t_slot_result want;
            results_checked++;
            if (awaited_results.size() == 0) begin
                report($sformatf("result with nothing awaited: status %0d slot %0d",
                                 status, slot));
                return;
            end
            want = awaited_results.pop_front();
            status_count[want.status]++;
            if (status !== want.status) begin
                report($sformatf("status got %0d want %0d (slot %0d)", status, want.status,
                                 want.slot));
            end
            if (slot !== want.slot) begin
                report($sformatf("slot got %0d want %0d", slot, want.slot));
            end
            if (seq !== want.seq) begin
                report($sformatf("slot_sequence got %0d want %0d (slot %0d)", seq, want.seq,
                                 want.slot));
            end
            if (in_use !== want.in_use) begin
                report($sformatf("in_use got %0b want %0b (slot %0d)", in_use, want.in_use,
                                 want.slot));
            end
        endtask

        function int outstanding();
            return awaited_results.size();
        endfunction

        function int pick_used_slot();
            int s;
            if (used_count <= FO) begin
                return FO;
            end
            repeat (16) begin
                s = $urandom_range(FO, table_size - 1);
                if (slot_used[s]) begin
                    return s;
                end
            end
            for (s = FO; s < table_size; s++) begin
                if (slot_used[s]) begin
                    return s;
                end
            end
            return FO;
        endfunction
    endclass

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_in_valid      = 1'b0;
    logic [OP_W-1:0]      i_opcode        = '0;
    logic [REC_W-1:0]     i_record_number = '0;
    logic [BASE_W-1:0]    i_base_record   = '0;
    logic [SEQ_W-1:0]     i_base_sequence = '0;
    logic                 i_out_stall     = 1'b0;
    logic                 i_cfg_valid     = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index     = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data      = '0;

    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [STATUS_W-1:0]  o_status;
    logic [REC_W-1:0]     o_slot;
    logic [SEQ_W-1:0]     o_slot_sequence;
    logic                 o_in_use;
    logic                 o_cfg_ready;

    allocator_scoreboard ledger = new();

    bit tx_quiet    = 1'b0;
    bit rx_quiet    = 1'b0;
    int burst_left  = 0;
    bit stall_on    = 1'b0;
    int stall_left  = 0;
    int idle_cycles = 0;
    int cfg_writes  = 0;

    bitmap_record_allocator_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_opcode        (i_opcode),
        .i_record_number (i_record_number),
        .i_base_record   (i_base_record),
        .i_base_sequence (i_base_sequence),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_slot          (o_slot),
        .o_slot_sequence (o_slot_sequence),
        .o_in_use        (o_in_use),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // result side stalls in runs of its own
    always @(negedge i_clk) begin
        if (!i_rst_n || rx_quiet) begin
            i_out_stall <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                stall_on   = ($urandom_range(0, 2) == 0);
                stall_left = stall_on ? $urandom_range(1, 6) : $urandom_range(1, 24);
            end
            stall_left = stall_left - 1;
            i_out_stall <= stall_on;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                ledger.check_result(o_status, o_slot, o_slot_sequence, o_in_use);
            end
            if (i_in_valid && !o_in_stall) begin
                ledger.note_request(i_opcode, i_record_number, i_base_record, i_base_sequence);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                ledger.write_reg(i_cfg_index, i_cfg_data);
                cfg_writes++;
            end
            if ((o_out_valid && !i_out_stall) || (i_in_valid && !o_in_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("no handshake for %0d cycles, %0d results still awaited",
                         idle_cycles, ledger.outstanding());
                $display("** bitmap_record_allocator_unit: FAILED **");
                $finish;
            end
        end
    end

    // entered and left just after a falling edge
    task automatic send_request(input logic [OP_W-1:0] op, input logic [REC_W-1:0] rec,
                                input logic [BASE_W-1:0] base,
                                input logic [SEQ_W-1:0] bseq);
        int gap;
        gap = 0;
        if (!tx_quiet) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
            burst_left--;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_opcode        <= op;
        i_record_number <= rec;
        i_base_record   <= base;
        i_base_sequence <= bseq;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (ledger.outstanding() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DAT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    task automatic set_config(input bit ro, input logic [REC_W-1:0] last_res);
        logic [31:0] noise;
        noise = $urandom;
        wait_idle();
        write_register(CFG_READ_ONLY, {noise[CFG_DAT_W-2:0], ro});
        write_register(CFG_LAST_RES, last_res);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [SEQ_W-1:0] nonzero_seq();
        return SEQ_W'($urandom_range(1, 16'hffff));
    endfunction

    function automatic logic [BASE_W-1:0] good_base();
        case ($urandom_range(0, 3))
            0:       return {36'd0, ledger.last_reserved} + 48'd1;
            1:       return BASE_MAX_OK;
            default: return BASE_W'($urandom_range(32'hffff_ffff, ledger.last_reserved + 1));
        endcase
    endfunction

    function automatic logic [BASE_W-1:0] bad_base();
        logic [63:0] wide;
        wide = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0:       return {36'd0, ledger.last_reserved};
            1:       return BASE_MAX_OK + 48'd1;
            2:       return wide[BASE_W-1:0];
            default: return BASE_W'($urandom_range(0, ledger.last_reserved));
        endcase
    endfunction

    task automatic random_request();
        int               pick;
        int               q;
        logic [31:0]      noise;
        logic [63:0]      wide;
        logic [REC_W-1:0] rec;
        pick  = $urandom_range(0, 99);
        noise = $urandom;
        wide  = {$urandom, $urandom};
        rec   = noise[REC_W-1:0];
        if (pick < 45) begin
            send_request(OP_ALLOC, rec, good_base(), nonzero_seq());
        end else if (pick < 70) begin
            if (noise[31:30] != 2'b00) begin
                rec = REC_W'(ledger.pick_used_slot());
            end
            send_request(OP_FREE, rec, wide[BASE_W-1:0], noise[31:16]);
        end else if (pick < 85) begin
            q = $urandom_range(0, ledger.table_size + 2);
            if (noise[29]) begin
                rec = REC_W'((q > NSL - 1) ? NSL - 1 : q);
            end
            send_request(OP_QUERY, rec, wide[BASE_W-1:0], noise[31:16]);
        end else begin
            case (noise[28:27])
                2'd0:    send_request(OP_UNUSED, rec, wide[BASE_W-1:0], noise[31:16]);
                2'd1:    send_request(OP_ALLOC, rec, good_base(), '0);
                2'd2:    send_request(OP_ALLOC, rec, bad_base(), nonzero_seq());
                default: send_request(noise[26] ? OP_FREE : OP_QUERY, rec, wide[BASE_W-1:0],
                                      noise[31:16]);
            endcase
        end
    endtask

    initial begin
        ledger.clear();
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // state straight out of reset
        send_request(OP_QUERY, '0, '0, '0);
        send_request(OP_QUERY, REC_W'(FO - 1), '0, '0);
        send_request(OP_QUERY, REC_W'(FO), '0, '0);
        send_request(OP_QUERY, 12'hfff, 48'hffff_ffff_ffff, 16'hffff);
        send_request(OP_FREE, '0, '0, '0);
        send_request(OP_FREE, REC_W'(FO - 1), '0, '0);
        send_request(OP_FREE, REC_W'(FO), '0, '0);
        send_request(OP_ALLOC, '0, 48'd15, 16'd1);
        send_request(OP_ALLOC, 12'hfff, 48'd16, 16'd1);
        send_request(OP_ALLOC, '0, 48'd100, 16'd0);
        send_request(OP_ALLOC, '0, BASE_MAX_OK + 48'd1, 16'hffff);
        send_request(OP_ALLOC, '0, 48'hffff_ffff_ffff, 16'd1);
        send_request(OP_ALLOC, '0, BASE_MAX_OK, 16'hffff);
        send_request(OP_FREE, REC_W'(FO), '0, '0);
        send_request(OP_FREE, REC_W'(FO), '0, '0);
        send_request(OP_QUERY, REC_W'(FO), '0, '0);
        send_request(OP_ALLOC, '0, 48'd1000, 16'h8000);
        send_request(OP_FREE, REC_W'(FO + 1), '0, '0);
        send_request(OP_FREE, 12'hfff, '0, '0);
        send_request(OP_UNUSED, 12'hfff, 48'hffff_ffff_ffff, 16'hffff);
        send_request(OP_UNUSED, '0, '0, '0);
        send_request(OP_QUERY, REC_W'(FO + 1), '0, '0);

        // read only refuses allocate and free
        set_config(1'b1, LAST_RES_RST);
        send_request(OP_ALLOC, '0, BASE_MAX_OK, 16'd1);
        send_request(OP_FREE, REC_W'(FO), '0, '0);
        send_request(OP_QUERY, REC_W'(FO), '0, '0);

        for (int p = 0; p < 5; p++) begin
            case (p)
                0:       set_config(1'b0, '0);
                1:       set_config(1'b1, 12'hfff);
                2:       set_config(1'b0, 12'hfff);
                3:       set_config(1'b0, REC_W'($urandom_range(0, 12'hfff)));
                default: set_config(1'b0, LAST_RES_RST);
            endcase
            tx_quiet = (p == 2);
            rx_quiet = (p == 3);
            repeat (PHASE_ITEMS) random_request();
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d requests, %0d results checked, %0d register writes, table at %0d slots",
                 ledger.requests_noted, ledger.results_checked, cfg_writes, ledger.table_size);
        $display("%0d grants, %0d table-full answers, %0d refusals, %0d sequence wraps",
                 ledger.grants, ledger.status_count[ST_FULL],
                 ledger.status_count[ST_BAD_STATE], ledger.seq_wraps);
        if (ledger.mismatches == 0) begin
            $display("** bitmap_record_allocator_unit: PASSED **");
        end else begin
            $display("** bitmap_record_allocator_unit: FAILED **");
        end
        $finish;
    end

endmodule
